// File: src/gews_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid edge weight store package
// Shared constants and codes for the grid edge weight store.
// ----------------------------------------------------------------------------
package gews_pkg;

	localparam int MAX_SIDE         = 64;
	localparam int EDGE_DEPTH_DEF   = 8192;
	localparam int WEIGHT_BITS_DEF  = 32;

	localparam int SIDE_W  = 7;
	localparam int COORD_W = 6;
	localparam int POS_W   = 16;
	localparam int OUT_W   = 32;

	localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RD_NONE  = 2'd1,
		ST_WR_NONE  = 2'd2
	} status_t;

endpackage

// File: src/gews_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gews_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/grid_edge_weight_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid edge weight store
// Reads and writes edge weights of a square grid graph held in one RAM.
// ----------------------------------------------------------------------------
// An accepted request is held in the first stage; its result is registered
// in the second stage when the output is not stalled. Throughput: one request
// per cycle while in_stall is low; the single RAM access per request in the
// second stage sets this figure. Reset: the side register returns to 64 and a
// clearing pass writes zero to all EDGE_DEPTH entries, one per cycle, while
// in_stall is held high. Configuration writes are taken throughout.
module grid_edge_weight_store #(
	parameter int EDGE_DEPTH  = gews_pkg::EDGE_DEPTH_DEF,
	parameter int WEIGHT_BITS = gews_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic        [gews_pkg::SIDE_W-1:0]    cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  cmd,
	input  logic        [gews_pkg::COORD_W-1:0]   row_a,
	input  logic        [gews_pkg::COORD_W-1:0]   col_a,
	input  logic        [gews_pkg::COORD_W-1:0]   row_b,
	input  logic        [gews_pkg::COORD_W-1:0]   col_b,
	input  logic signed [gews_pkg::OUT_W-1:0]     new_weight,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [gews_pkg::OUT_W-1:0]     weight_out,
	output logic        [1:0]                     status
);

	localparam int AW = $clog2(EDGE_DEPTH);
	localparam int SW = gews_pkg::SIDE_W;
	localparam int CW = gews_pkg::COORD_W;
	localparam int PW = gews_pkg::POS_W;

	logic [SW-1:0]          side_q;
	logic                   clearing_q;
	logic [AW-1:0]          clr_cnt_q;

	logic                   v_s1;
	logic                   cmd_s1;
	logic                   present_s1;
	logic [AW-1:0]          addr_s1;
	logic [WEIGHT_BITS-1:0] wdata_s1;

	logic                   out_valid_q;
	logic                   rd_ok_s2;
	gews_pkg::status_t      status_s2;

	logic                   accept;
	logic                   adv;
	logic [SW-1:0]          side_eff;
	logic [SW-1:0]          side_m1;
	logic [CW-1:0]          rlo, rhi, clo, chi;
	logic                   in_grid;
	logic                   adjacent;
	logic                   boundary;
	logic                   vertical;
	logic [SW:0]            mul_b;
	logic [PW-1:0]          mul_p;
	logic [PW-1:0]          pos;
	logic [31:0]            pos32;
	logic                   present;
	logic signed [63:0]     new_w64;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [WEIGHT_BITS-1:0] ram_wdata;
	logic                   ram_re;
	logic [WEIGHT_BITS-1:0] ram_rdata;
	logic signed [63:0]     rd_w64;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= gews_pkg::SIDE_RESET;
		end else if (cfg_we) begin
			side_q <= cfg_wdata;
		end
	end

	always_comb begin
		if ({2'b00, side_q} > 9'(gews_pkg::MAX_SIDE)) begin
			side_eff = SW'(gews_pkg::MAX_SIDE);
		end else begin
			side_eff = side_q;
		end
		side_m1 = side_eff - SW'(1);

		rlo = (row_a < row_b) ? row_a : row_b;
		rhi = (row_a < row_b) ? row_b : row_a;
		clo = (col_a < col_b) ? col_a : col_b;
		chi = (col_a < col_b) ? col_b : col_a;

		in_grid = ({1'b0, row_a} < side_eff) && ({1'b0, row_b} < side_eff) &&
			({1'b0, col_a} < side_eff) && ({1'b0, col_b} < side_eff);
		adjacent = ((rhi - rlo == CW'(1)) && (chi == clo)) ||
			((rhi == rlo) && (chi - clo == CW'(1)));
		boundary = ((row_a == '0) && (row_b == '0)) ||
			(({1'b0, row_a} == side_m1) && ({1'b0, row_b} == side_m1));
		vertical = (clo == chi);

		// Horizontal index folds to (side-1)*(side+rlo-1) + clo.
		if (vertical) begin
			mul_b = {2'b00, clo};
		end else begin
			mul_b = {1'b0, side_eff} + {2'b00, rlo} - (SW+1)'(1);
		end
		mul_p = PW'(side_m1) * PW'(mul_b);
		pos   = mul_p + PW'(vertical ? rlo : clo);
		pos32 = 32'(pos);

		present = (side_eff >= SW'(2)) && in_grid && adjacent && !boundary &&
			(pos32 < 32'(EDGE_DEPTH));

		new_w64 = 64'(new_weight);
	end

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = clearing_q || (v_s1 && !adv);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == AW'(EDGE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			present_s1 <= present;
			addr_s1    <= pos32[AW-1:0];
			wdata_s1   <= new_w64[WEIGHT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_ok_s2 <= (cmd_s1 == gews_pkg::CMD_READ) && present_s1;
			if (present_s1) begin
				status_s2 <= gews_pkg::ST_OK;
			end else if (cmd_s1 == gews_pkg::CMD_WRITE) begin
				status_s2 <= gews_pkg::ST_WR_NONE;
			end else begin
				status_s2 <= gews_pkg::ST_RD_NONE;
			end
		end
	end

	always_comb begin
		ram_re = v_s1 && adv;
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = v_s1 && adv && (cmd_s1 == gews_pkg::CMD_WRITE) && present_s1;
			ram_waddr = addr_s1;
			ram_wdata = wdata_s1;
		end
	end

	gews_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (EDGE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_s1),
		.rdata (ram_rdata)
	);

	assign rd_w64     = 64'(signed'(ram_rdata));
	assign out_valid  = out_valid_q;
	assign status     = status_s2;
	assign weight_out = rd_ok_s2 ? rd_w64[gews_pkg::OUT_W-1:0] : '0;

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> in_stall)
		else $error("request port open during clearing pass");

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !v_s1 && !out_valid_q)
		else $error("request in flight during clearing pass");

	a_read_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> adv && !clearing_q)
		else $error("RAM read while result slot is blocked");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != gews_pkg::ST_OK) |-> weight_out == '0)
		else $error("nonzero weight on absent edge");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> !ram_re || $past(!ram_re))
		else $error("RAM read data overwritten under stall");

endmodule
